// ----- hw/rtl/two_body_gravity_step_defines.svh -----
// Assertion macros for the two-body gravity stepper.
// Define SYNTH to compile them away.
`ifndef TWO_BODY_GRAVITY_STEP_DEFINES_SVH
`define TWO_BODY_GRAVITY_STEP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define GBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gbs assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gbs assertion failed");
`else
`define GBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/gbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;
	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 32;
	localparam int MAG_W     = POS_W + 1;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int ROOT_W    = MAG_W;
	localparam int DEN_W     = ROOT_W;
	localparam int REM_W     = ROOT_W + 2;
	localparam int K_W       = 56;
	localparam int HALF_W    = K_W / 2;
	localparam int CNT_W     = 6;

	localparam logic [DEN_W-1:0] ONE_Q = {{(DEN_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(K_W);
	localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ROOT_W);

	typedef enum logic {
		ITER_DIV,
		ITER_SQRT
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/two_body_gravity_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "two_body_gravity_step_defines.svh"
// Two-body gravity stepper. The block holds the position and velocity of two bodies in
// signed Q15.16 and, for every step request, pulls each body toward the other by
// G*m_other*delta/d^3*dt (d clamped to at least 1.0), then moves each body by its new
// velocity times dt; a load request instead writes one body's state. Each request
// returns both positions, the separation and both speeds, with a flag set when any
// value was clipped. The work is done by one registered 33x33 multiplier and one
// bit-serial divide/square-root unit under a sequencer, and the block accepts no new
// request until the current one is finished. A step request uses six divisions for
// the inverse-cube scaling and three square roots; a load request uses three square
// roots. A finished result waits in an output register, so the next request may be
// accepted while it is still pending. Configuration writes must be made while the
// block is idle.
module two_body_gravity_step import gbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic               body_sel,
	input  logic signed [31:0] load_pos_x,
	input  logic signed [31:0] load_pos_y,
	input  logic signed [31:0] load_vel_x,
	input  logic signed [31:0] load_vel_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] first_x,
	output logic signed [31:0] first_y,
	output logic signed [31:0] second_x,
	output logic signed [31:0] second_y,
	output logic [31:0]        separation,
	output logic [31:0]        speed_first,
	output logic [31:0]        speed_second,
	output logic               saturated
);
	// Register indexes of the configuration port.
	localparam logic [1:0] REG_MASS_FIRST  = 2'd0;
	localparam logic [1:0] REG_MASS_SECOND = 2'd1;
	localparam logic [1:0] REG_GRAV_CONST  = 2'd2;
	localparam logic [1:0] REG_TIME_STEP   = 2'd3;

	localparam logic MODE_LOAD = 1'b1;
	localparam logic BODY_SECOND = 1'b1;

	localparam logic [23:0] MASS_FIRST_RST  = 24'd100000;
	localparam logic [23:0] MASS_SECOND_RST = 24'd30;
	localparam logic [15:0] GRAV_CONST_RST  = 16'd1000;
	localparam logic [15:0] TIME_STEP_RST   = 16'd1092;

	localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] I32_MIN = 32'h8000_0000;
	localparam logic [45:0] DV_CAP  = 46'd1 << 33;

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF,
		S_NA, S_NB, S_NC, S_ND, S_NW,
		S_GT, S_GT1, S_GT2, S_KB, S_KA, S_KB2,
		S_DIV, S_DIVW,
		S_PL, S_PH, S_PC, S_PD, S_PE,
		S_DA, S_DB, S_DC,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		N_SEP,
		N_SPD1,
		N_SPD2
	} norm_sel_t;

	function automatic logic [MAG_W-1:0] mag33(input logic signed [MAG_W-1:0] v);
		logic [MAG_W-1:0] r;
		r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
		return r;
	endfunction

	// Returns {clipped, value} of a 35-bit signed sum squeezed into 32 bits.
	function automatic logic [32:0] sat32(input logic signed [34:0] s);
		logic [32:0] r;
		if (s[34:31] == {4{s[34]}}) begin
			r = {1'b0, s[31:0]};
		end else if (s[34]) begin
			r = {1'b1, I32_MIN};
		end else begin
			r = {1'b1, I32_MAX};
		end
		return r;
	endfunction

	// Configuration registers.
	logic [23:0] mass_first_q, mass_second_q;
	logic [15:0] grav_const_q, time_step_q;

	// Body state.
	logic signed [31:0] pos_first_x_q, pos_first_y_q, pos_second_x_q, pos_second_y_q;
	logic signed [31:0] vel_first_x_q, vel_first_y_q, vel_second_x_q, vel_second_y_q;

	// Sequencer and working registers.
	state_t            state_q;
	norm_sel_t         nsel_q;
	logic              mode_q;
	logic              sat_q;
	logic [MAG_W-1:0]  adx_q, ady_q;
	logic              sdx_q, sdy_q;
	logic [MAG_W-1:0]  opa_q, opb_q;
	logic [PROD_W-1:0] acc_q;
	logic [DEN_W-1:0]  d_q;
	logic [31:0]       sep_q, speed1_q, speed2_q;
	logic [K_W-1:0]    ka_q, kb_q;
	logic [33:0]       mag_q;
	logic [1:0]        idx_q;
	logic              ksel_q;
	logic [1:0]        dcnt_q;

	// Result register.
	logic               out_valid_q;
	logic signed [31:0] res_first_x_q, res_first_y_q, res_second_x_q, res_second_y_q;
	logic [31:0]        res_sep_q, res_speed1_q, res_speed2_q;
	logic               res_sat_q;

	// Shared units.
	logic [PROD_W-1:0] prod;
	iter_ctl_t         iter_ctl;
	iter_sts_t         iter_sts;
	logic [K_W-1:0]    iter_res;
	logic [K_W-1:0]    k_div;
	logic [DEN_W-1:0]  div_rem0;
	logic [K_W-1:0]    div_num;
	logic [PROD_W-1:0] sqrt_rad;

	// Combinational helpers.
	logic signed [MAG_W-1:0] dx, dy;
	logic [MAG_W-1:0]        norm_a, norm_b;
	logic signed [31:0]      v_sel, p_sel;
	logic [K_W-1:0]          k_pull;
	logic [MAG_W-1:0]        dmag;
	logic                    pull_neg;
	logic                    hi_big;
	logic [45:0]             msum;
	logic signed [34:0]      vsum, psum;
	logic [32:0]             vsat, psat;
	logic [30:0]             dm;
	logic [ROOT_W-1:0]       root;
	logic [DEN_W-1:0]        dcl;

	gbs_mul u_mul (
		.clk     (clk),
		.a       (opa_q),
		.b       (opb_q),
		.prod_s1 (prod)
	);

	gbs_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (iter_ctl),
		.div_rem0 (div_rem0),
		.div_den  (d_q),
		.div_num  (div_num),
		.sqrt_rad (sqrt_rad),
		.sts      (iter_sts),
		.result   (iter_res)
	);

	// The divider starts with the top FRAC_BITS of the scaled dividend already in the
	// remainder: they are below d, so those quotient bits are known to be zero.
	assign k_div    = ksel_q ? kb_q : ka_q;
	assign div_num  = {k_div[K_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
	assign div_rem0 = DEN_W'(k_div >> (K_W - FRAC_BITS));
	assign sqrt_rad = acc_q + prod;

	assign iter_ctl.start = (state_q == S_ND) || (state_q == S_DIV);
	assign iter_ctl.op    = (state_q == S_ND) ? ITER_SQRT : ITER_DIV;

	assign dx = {pos_second_x_q[31], pos_second_x_q} - {pos_first_x_q[31], pos_first_x_q};
	assign dy = {pos_second_y_q[31], pos_second_y_q} - {pos_first_y_q[31], pos_first_y_q};

	always_comb begin
		case (nsel_q)
			N_SPD1: begin
				norm_a = mag33({vel_first_x_q[31], vel_first_x_q});
				norm_b = mag33({vel_first_y_q[31], vel_first_y_q});
			end
			N_SPD2: begin
				norm_a = mag33({vel_second_x_q[31], vel_second_x_q});
				norm_b = mag33({vel_second_y_q[31], vel_second_y_q});
			end
			default: begin
				norm_a = adx_q;
				norm_b = ady_q;
			end
		endcase
	end

	// idx_q walks first x, first y, second x, second y for both the pull and the drift.
	always_comb begin
		case (idx_q)
			2'd0: begin
				v_sel = vel_first_x_q;
				p_sel = pos_first_x_q;
			end
			2'd1: begin
				v_sel = vel_first_y_q;
				p_sel = pos_first_y_q;
			end
			2'd2: begin
				v_sel = vel_second_x_q;
				p_sel = pos_second_x_q;
			end
			default: begin
				v_sel = vel_second_y_q;
				p_sel = pos_second_y_q;
			end
		endcase
	end

	// The second body is pulled the opposite way along the same difference.
	assign k_pull   = idx_q[1] ? kb_q : ka_q;
	assign dmag     = idx_q[0] ? ady_q : adx_q;
	assign pull_neg = (idx_q[0] ? sdy_q : sdx_q) ^ idx_q[1];

	// Pull magnitude: ((k_hi*|delta|) << 28 + k_lo*|delta|) >> 16, capped at 2^33.
	// prod holds the high partial product and acc_q the low one.
	assign hi_big = |prod[PROD_W-1:22];
	assign msum   = (46'(prod[21:0]) << 12) + 46'(acc_q[60:16]);

	assign vsum = pull_neg ? (35'(v_sel) - 35'(mag_q)) : (35'(v_sel) + 35'(mag_q));
	assign vsat = sat32(vsum);

	// Drift magnitude |v|*dt >> 16 fits in 31 bits.
	assign dm   = prod[46:16];
	assign psum = v_sel[31] ? (35'(p_sel) - 35'(dm)) : (35'(p_sel) + 35'(dm));
	assign psat = sat32(psum);

	assign root = iter_res[ROOT_W-1:0];
	assign dcl  = (root < ONE_Q) ? ONE_Q : root;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_first_q  <= MASS_FIRST_RST;
			mass_second_q <= MASS_SECOND_RST;
			grav_const_q  <= GRAV_CONST_RST;
			time_step_q   <= TIME_STEP_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MASS_FIRST:  mass_first_q  <= cfg_data;
				REG_MASS_SECOND: mass_second_q <= cfg_data;
				REG_GRAV_CONST:  grav_const_q  <= cfg_data[15:0];
				REG_TIME_STEP:   time_step_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer, body state, working registers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			nsel_q         <= N_SEP;
			mode_q         <= 1'b0;
			sat_q          <= 1'b0;
			pos_first_x_q  <= '0;
			pos_first_y_q  <= '0;
			pos_second_x_q <= '0;
			pos_second_y_q <= '0;
			vel_first_x_q  <= '0;
			vel_first_y_q  <= '0;
			vel_second_x_q <= '0;
			vel_second_y_q <= '0;
			adx_q          <= '0;
			ady_q          <= '0;
			sdx_q          <= 1'b0;
			sdy_q          <= 1'b0;
			opa_q          <= '0;
			opb_q          <= '0;
			acc_q          <= '0;
			d_q            <= ONE_Q;
			sep_q          <= '0;
			speed1_q       <= '0;
			speed2_q       <= '0;
			ka_q           <= '0;
			kb_q           <= '0;
			mag_q          <= '0;
			idx_q          <= '0;
			ksel_q         <= 1'b0;
			dcnt_q         <= '0;
			out_valid_q    <= 1'b0;
			res_first_x_q  <= '0;
			res_first_y_q  <= '0;
			res_second_x_q <= '0;
			res_second_y_q <= '0;
			res_sep_q      <= '0;
			res_speed1_q   <= '0;
			res_speed2_q   <= '0;
			res_sat_q      <= 1'b0;
		end else begin
			// In the hand-over state the output register is managed below.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						sat_q  <= 1'b0;
						if (mode == MODE_LOAD) begin
							if (body_sel == BODY_SECOND) begin
								pos_second_x_q <= load_pos_x;
								pos_second_y_q <= load_pos_y;
								vel_second_x_q <= load_vel_x;
								vel_second_y_q <= load_vel_y;
							end else begin
								pos_first_x_q <= load_pos_x;
								pos_first_y_q <= load_pos_y;
								vel_first_x_q <= load_vel_x;
								vel_first_y_q <= load_vel_y;
							end
						end
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					adx_q   <= mag33(dx);
					ady_q   <= mag33(dy);
					sdx_q   <= dx[MAG_W-1];
					sdy_q   <= dy[MAG_W-1];
					nsel_q  <= N_SEP;
					state_q <= S_NA;
				end
				// Vector length: square both parts, add, then take the root.
				S_NA: begin
					opa_q   <= norm_a;
					opb_q   <= norm_a;
					state_q <= S_NB;
				end
				S_NB: begin
					opa_q   <= norm_b;
					opb_q   <= norm_b;
					state_q <= S_NC;
				end
				S_NC: begin
					acc_q   <= prod;
					state_q <= S_ND;
				end
				S_ND: begin
					state_q <= S_NW;
				end
				S_NW: begin
					if (iter_sts.done) begin
						case (nsel_q)
							N_SEP: begin
								d_q   <= dcl;
								sep_q <= dcl[DEN_W-1] ? '1 : dcl[31:0];
								if (dcl[DEN_W-1]) begin
									sat_q <= 1'b1;
								end
								if (mode_q == MODE_LOAD) begin
									nsel_q  <= N_SPD1;
									state_q <= S_NA;
								end else begin
									state_q <= S_GT;
								end
							end
							N_SPD1: begin
								speed1_q <= root[31:0];
								nsel_q   <= N_SPD2;
								state_q  <= S_NA;
							end
							default: begin
								speed2_q <= root[31:0];
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				// k = G*dt*m for each body's partner.
				S_GT: begin
					opa_q   <= MAG_W'(grav_const_q);
					opb_q   <= MAG_W'(time_step_q);
					state_q <= S_GT1;
				end
				S_GT1: begin
					state_q <= S_GT2;
				end
				S_GT2: begin
					opa_q   <= MAG_W'(prod[31:0]);
					opb_q   <= MAG_W'(mass_second_q);
					state_q <= S_KB;
				end
				S_KB: begin
					opb_q   <= MAG_W'(mass_first_q);
					state_q <= S_KA;
				end
				S_KA: begin
					ka_q    <= prod[K_W-1:0];
					state_q <= S_KB2;
				end
				S_KB2: begin
					kb_q    <= prod[K_W-1:0];
					ksel_q  <= 1'b0;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				// Three divisions by d for each k give the inverse-cube factor.
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (iter_sts.done) begin
						if (ksel_q) begin
							kb_q <= iter_res;
						end else begin
							ka_q <= iter_res;
						end
						if (dcnt_q == 2'd2) begin
							dcnt_q <= '0;
							if (ksel_q) begin
								idx_q   <= '0;
								state_q <= S_PL;
							end else begin
								ksel_q  <= 1'b1;
								state_q <= S_DIV;
							end
						end else begin
							dcnt_q  <= dcnt_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				// Velocity change for one axis of one body.
				S_PL: begin
					opa_q   <= MAG_W'(k_pull[HALF_W-1:0]);
					opb_q   <= dmag;
					state_q <= S_PH;
				end
				S_PH: begin
					opa_q   <= MAG_W'(k_pull[K_W-1:HALF_W]);
					state_q <= S_PC;
				end
				S_PC: begin
					acc_q   <= prod;
					state_q <= S_PD;
				end
				S_PD: begin
					mag_q   <= (hi_big || (msum > DV_CAP)) ? DV_CAP[33:0] : msum[33:0];
					state_q <= S_PE;
				end
				S_PE: begin
					case (idx_q)
						2'd0:    vel_first_x_q  <= vsat[31:0];
						2'd1:    vel_first_y_q  <= vsat[31:0];
						2'd2:    vel_second_x_q <= vsat[31:0];
						default: vel_second_y_q <= vsat[31:0];
					endcase
					if (vsat[32]) begin
						sat_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == 2'd3) begin
						state_q <= S_DA;
					end else begin
						state_q <= S_PL;
					end
				end
				// Position change from the new velocity.
				S_DA: begin
					opa_q   <= mag33({v_sel[31], v_sel});
					opb_q   <= MAG_W'(time_step_q);
					state_q <= S_DB;
				end
				S_DB: begin
					state_q <= S_DC;
				end
				S_DC: begin
					case (idx_q)
						2'd0:    pos_first_x_q  <= psat[31:0];
						2'd1:    pos_first_y_q  <= psat[31:0];
						2'd2:    pos_second_x_q <= psat[31:0];
						default: pos_second_y_q <= psat[31:0];
					endcase
					if (psat[32]) begin
						sat_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == 2'd3) begin
						nsel_q  <= N_SPD1;
						state_q <= S_NA;
					end else begin
						state_q <= S_DA;
					end
				end
				// Hand the result over once the output register is free.
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						res_first_x_q  <= pos_first_x_q;
						res_first_y_q  <= pos_first_y_q;
						res_second_x_q <= pos_second_x_q;
						res_second_y_q <= pos_second_y_q;
						res_sep_q      <= sep_q;
						res_speed1_q   <= speed1_q;
						res_speed2_q   <= speed2_q;
						res_sat_q      <= sat_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign first_x      = res_first_x_q;
	assign first_y      = res_first_y_q;
	assign second_x     = res_second_x_q;
	assign second_y     = res_second_y_q;
	assign separation   = res_sep_q;
	assign speed_first  = res_speed1_q;
	assign speed_second = res_speed2_q;
	assign saturated    = res_sat_q;

	// The shared divide/root unit is only started when it is free.
	`GBS_ASSERT_IMPL(a_start_free, clk, arst_n, iter_ctl.start, !iter_sts.busy)
	// A finished division or root is only produced while the sequencer waits for it.
	`GBS_ASSERT_IMPL(a_done_waited, clk, arst_n, iter_sts.done, (state_q == S_NW) || (state_q == S_DIVW))
	// Once a request is taken, no second one is taken in the next cycle.
	`GBS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	// The forces are never computed with a separation below one.
	`GBS_ASSERT_IMPL(a_sep_clamped, clk, arst_n, state_q == S_GT, d_q >= ONE_Q)
endmodule
`default_nettype wire

// ----- hw/rtl/gbs_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gbs_mul import gbs_pkg::*; (
	input  logic              clk,
	input  logic [MAG_W-1:0]  a,
	input  logic [MAG_W-1:0]  b,
	output logic [PROD_W-1:0] prod_s1
);
	// Unsigned product, registered once.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end
endmodule
`default_nettype wire

// ----- hw/rtl/gbs_iter.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gbs_iter import gbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  iter_ctl_t         ctl,
	input  logic [DEN_W-1:0]  div_rem0,
	input  logic [DEN_W-1:0]  div_den,
	input  logic [K_W-1:0]    div_num,
	input  logic [PROD_W-1:0] sqrt_rad,
	output iter_sts_t         sts,
	output logic [K_W-1:0]    result
);
	logic              busy_q;
	logic              done_q;
	iter_op_t          op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [PROD_W-1:0] wrk_q;
	logic [ROOT_W-1:0] root_q;

	logic [DEN_W:0]    div_t;
	logic              div_ge;
	logic [DEN_W:0]    div_nrem;
	logic [REM_W+1:0]  sq_r4;
	logic [REM_W+1:0]  sq_trial;
	logic              sq_ge;
	logic [REM_W+1:0]  sq_nrem;

	// Restoring division: one quotient bit per cycle, shifted into the work word.
	assign div_t    = {rem_q[DEN_W-1:0], wrk_q[K_W-1]};
	assign div_ge   = div_t >= {1'b0, den_q};
	assign div_nrem = div_ge ? (div_t - {1'b0, den_q}) : div_t;

	// Digit-by-digit square root: two radicand bits per cycle.
	assign sq_r4    = {rem_q, wrk_q[PROD_W-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_r4 >= sq_trial;
	assign sq_nrem  = sq_ge ? (sq_r4 - sq_trial) : sq_r4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ITER_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == ITER_DIV) ? (DIV_STEPS - 1'b1) : (SQRT_STEPS - 1'b1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			den_q  <= div_den;
			root_q <= '0;
			if (ctl.op == ITER_DIV) begin
				rem_q <= REM_W'(div_rem0);
				wrk_q <= PROD_W'(div_num);
			end else begin
				rem_q <= '0;
				wrk_q <= sqrt_rad;
			end
		end else if (busy_q) begin
			if (op_q == ITER_DIV) begin
				rem_q <= REM_W'(div_nrem[DEN_W-1:0]);
				wrk_q <= {wrk_q[PROD_W-2:0], div_ge};
			end else begin
				rem_q  <= sq_nrem[REM_W-1:0];
				wrk_q  <= {wrk_q[PROD_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = (op_q == ITER_DIV) ? wrk_q[K_W-1:0] : K_W'(root_q);
endmodule
`default_nettype wire

// ----- bench/tb_two_body_gravity_step.sv -----
`timescale 1ns / 1ps
module tb_two_body_gravity_step;
	import gbs_pkg::*;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_MASS_FIRST  = 2'd0;
	localparam logic [1:0] REG_MASS_SECOND = 2'd1;
	localparam logic [1:0] REG_GRAV_CONST  = 2'd2;
	localparam logic [1:0] REG_TIME_STEP   = 2'd3;

	// Request kinds and body selection.
	localparam logic MODE_STEP   = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;
	localparam logic BODY_FIRST  = 1'b0;
	localparam logic BODY_SECOND = 1'b1;

	localparam logic [63:0] UNIT_Q   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] PULL_CAP = 64'd1 << 33;
	localparam longint      POS_MAX  = 64'sd2147483647;
	localparam longint      POS_MIN  = -64'sd2147483648;
	localparam int          CYCLE_LIMIT = 4000000;
	localparam int          SETTLE_CYCLES = 700;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [1:0]         cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic               body_sel;
	logic signed [31:0] load_pos_x;
	logic signed [31:0] load_pos_y;
	logic signed [31:0] load_vel_x;
	logic signed [31:0] load_vel_y;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic [31:0]        separation;
	logic [31:0]        speed_first;
	logic [31:0]        speed_second;
	logic               saturated;

	two_body_gravity_step u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.body_sel(body_sel),
		.load_pos_x(load_pos_x),
		.load_pos_y(load_pos_y),
		.load_vel_x(load_vel_x),
		.load_vel_y(load_vel_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.first_x(first_x),
		.first_y(first_y),
		.second_x(second_x),
		.second_y(second_y),
		.separation(separation),
		.speed_first(speed_first),
		.speed_second(speed_second),
		.saturated(saturated)
	);

	// One expected result: the body snapshot the block must report after a request.
	typedef struct {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic [31:0]        separation;
		logic [31:0]        speed_first;
		logic [31:0]        speed_second;
		logic               saturated;
	} snapshot_t;

	snapshot_t expected_snapshots[$];

	// Shadow copy of the configuration and of the two bodies. Positions and
	// velocities are kept as 64-bit integers that always hold 32-bit values.
	logic [63:0] mass_a, mass_b, grav_k, tick_len;
	longint      ax, ay, bx, by, avx, avy, bvx, bvy;
	bit          clip_seen;

	int  error_count;
	int  requests_sent;
	int  results_seen;
	int  loads_sent;
	int  clipped_results;
	int  cycle_count;
	bit  calm_receiver;

	// Clock and a watchdog that ends a hung run.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, expected_snapshots.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Floor square root, bit by bit, of a value of up to 66 bits.
	function automatic logic [63:0] floor_sqrt(logic [127:0] v);
		logic [127:0] root, rem, trial;
		root = '0;
		rem = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			root = root << 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 128'd1;
			end
		end
		return root[63:0];
	endfunction

	function automatic logic [63:0] vector_length(longint a, longint b);
		logic [127:0] x, y;
		x = {64'd0, magnitude(a)};
		y = {64'd0, magnitude(b)};
		return floor_sqrt(x * x + y * y);
	endfunction

	// floor(a*b/c), saturating to all ones when the quotient exceeds 64 bits.
	function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
			logic [63:0] c);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		if ((prod >> 64) >= {64'd0, c})
			return '1;
		return 64'(prod / {64'd0, c});
	endfunction

	// Velocity change toward the other body: G*m*dt*delta/d^3, truncated toward zero.
	function automatic longint gravity_pull(logic [63:0] mass, longint delta, logic [63:0] d);
		logic [63:0] q, m;
		q = grav_k * mass * tick_len;
		q = scaled_quotient(q, UNIT_Q, d);
		q = scaled_quotient(q, UNIT_Q, d);
		q = scaled_quotient(q, UNIT_Q, d);
		m = scaled_quotient(q, magnitude(delta), 64'd65536);
		if (m > PULL_CAP)
			m = PULL_CAP;
		return delta < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint position_drift(longint v);
		longint m;
		m = longint'((magnitude(v) * tick_len) >> 16);
		return v < 0 ? -m : m;
	endfunction

	function automatic longint clip_add(longint v, longint d);
		longint s;
		s = v + d;
		if (s > POS_MAX) begin
			clip_seen = 1'b1;
			return POS_MAX;
		end
		if (s < POS_MIN) begin
			clip_seen = 1'b1;
			return POS_MIN;
		end
		return s;
	endfunction

	function automatic logic [63:0] clamped_separation();
		logic [63:0] d;
		d = vector_length(bx - ax, by - ay);
		return d < UNIT_Q ? UNIT_Q : d;
	endfunction

	// Applies one accepted request to the shadow bodies and returns what the
	// block has to report for it.
	function automatic snapshot_t advance_bodies(logic req_mode, logic req_body,
			logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] vx, logic signed [31:0] vy);
		snapshot_t s;
		logic [63:0] d;
		longint dx, dy;
		clip_seen = 1'b0;
		if (req_mode == MODE_LOAD) begin
			if (req_body == BODY_SECOND) begin
				bx = px; by = py; bvx = vx; bvy = vy;
			end else begin
				ax = px; ay = py; avx = vx; avy = vy;
			end
			d = clamped_separation();
		end else begin
			dx = bx - ax;
			dy = by - ay;
			d = clamped_separation();
			avx = clip_add(avx, gravity_pull(mass_b, dx, d));
			avy = clip_add(avy, gravity_pull(mass_b, dy, d));
			bvx = clip_add(bvx, -gravity_pull(mass_a, dx, d));
			bvy = clip_add(bvy, -gravity_pull(mass_a, dy, d));
			ax = clip_add(ax, position_drift(avx));
			ay = clip_add(ay, position_drift(avy));
			bx = clip_add(bx, position_drift(bvx));
			by = clip_add(by, position_drift(bvy));
		end
		if (d > 64'hFFFF_FFFF) begin
			d = 64'hFFFF_FFFF;
			clip_seen = 1'b1;
		end
		s.first_x = 32'(ax);
		s.first_y = 32'(ay);
		s.second_x = 32'(bx);
		s.second_y = 32'(by);
		s.separation = d[31:0];
		s.speed_first = 32'(vector_length(avx, avy));
		s.speed_second = 32'(vector_length(bvx, bvy));
		s.saturated = clip_seen;
		return s;
	endfunction

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// Result side: out_ready stalls at random, except while calm_receiver is set.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0 && !calm_receiver) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!calm_receiver && $urandom_range(0, 3) == 0)
					stall_left = random_gap() + 1;
			end
		end
	end

	// Every result that leaves the block is checked against the oldest expectation.
	always @(posedge clk) begin
		snapshot_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_snapshots.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				e = expected_snapshots.pop_front();
				if (e.saturated)
					clipped_results++;
				if (first_x !== e.first_x) begin
					$error("first_x: expected %0d, got %0d", e.first_x, first_x);
					error_count++;
				end
				if (first_y !== e.first_y) begin
					$error("first_y: expected %0d, got %0d", e.first_y, first_y);
					error_count++;
				end
				if (second_x !== e.second_x) begin
					$error("second_x: expected %0d, got %0d", e.second_x, second_x);
					error_count++;
				end
				if (second_y !== e.second_y) begin
					$error("second_y: expected %0d, got %0d", e.second_y, second_y);
					error_count++;
				end
				if (separation !== e.separation) begin
					$error("separation: expected %0d, got %0d", e.separation, separation);
					error_count++;
				end
				if (speed_first !== e.speed_first) begin
					$error("speed_first: expected %0d, got %0d", e.speed_first, speed_first);
					error_count++;
				end
				if (speed_second !== e.speed_second) begin
					$error("speed_second: expected %0d, got %0d", e.speed_second,
						speed_second);
					error_count++;
				end
				if (saturated !== e.saturated) begin
					$error("saturated: expected %0d, got %0d", e.saturated, saturated);
					error_count++;
				end
			end
		end
	end

	// Presents one request, waits for the handshake and records its expected result.
	// It is entered right after a rising edge and leaves right after one; valid is
	// only lowered when a gap follows, so back-to-back requests keep it high.
	task automatic send_request(logic req_mode, logic req_body,
			logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] vx, logic signed [31:0] vy);
		int gap;
		in_valid <= 1'b1;
		mode <= req_mode;
		body_sel <= req_body;
		load_pos_x <= px;
		load_pos_y <= py;
		load_vel_x <= vx;
		load_vel_y <= vy;
		do
			@(posedge clk);
		while (!in_ready);
		expected_snapshots.push_back(advance_bodies(req_mode, req_body, px, py, vx, vy));
		requests_sent++;
		if (req_mode == MODE_LOAD)
			loads_sent++;
		gap = random_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic step_once();
		send_request(MODE_STEP, 1'($urandom), $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic load_body(logic which, logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] vx, logic signed [31:0] vy);
		send_request(MODE_LOAD, which, px, py, vx, vy);
	endtask

	// Stops sending and waits until every outstanding result has come back, then
	// lets the sequencer settle before anything else touches the block.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_snapshots.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Writes one register; only called while the block is idle.
	task automatic write_register(logic [1:0] index, logic [23:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (index)
			REG_MASS_FIRST: mass_a = {40'd0, value};
			REG_MASS_SECOND: mass_b = {40'd0, value};
			REG_GRAV_CONST: grav_k = {48'd0, value[15:0]};
			REG_TIME_STEP: tick_len = {48'd0, value[15:0]};
			default: ;
		endcase
	endtask

	task automatic write_all_registers(logic [23:0] ma, logic [23:0] mb,
			logic [15:0] g, logic [15:0] dt);
		drain_results();
		write_register(REG_MASS_FIRST, ma);
		write_register(REG_MASS_SECOND, mb);
		write_register(REG_GRAV_CONST, {8'd0, g});
		write_register(REG_TIME_STEP, {8'd0, dt});
	endtask

	// A position or velocity near the origin, in units of 1/65536, for orbits
	// that stay well inside the number range.
	function automatic logic signed [31:0] near_value(int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// Both bodies start at the origin: the separation is clamped to one and the
	// zero offset gives no pull.
	task automatic test_reset_state();
		step_once();
		step_once();
	endtask

	// A small orbit under the default configuration.
	task automatic test_default_orbit();
		load_body(BODY_FIRST, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		load_body(BODY_SECOND, 32'sd10 << 16, 32'sd0, 32'sd0, 32'sd5 << 16);
		repeat (4) step_once();
	endtask

	// Bodies at opposite corners of the number range: the separation saturates on
	// load and on step; huge velocities then push positions into both limits.
	task automatic test_range_limits();
		load_body(BODY_FIRST, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000);
		load_body(BODY_SECOND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF);
		step_once();
		load_body(BODY_FIRST, 32'sh7FFF_FF00, 32'sh8000_0100, 32'sh7FFF_FFFF,
			32'sh8000_0000);
		step_once();
	endtask

	// Largest masses, constant and tick, bodies 1/65536 apart per axis: the pull
	// hits its cap and the velocities saturate. Then the smallest settings.
	task automatic test_config_extremes();
		write_all_registers(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
		load_body(BODY_FIRST, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		load_body(BODY_SECOND, 32'sd1, 32'sd1, 32'sd0, 32'sd0);
		step_once();
		step_once();
		write_all_registers(24'd1, 24'd1, 16'd0, 16'd1);
		load_body(BODY_FIRST, -32'sd3 << 16, 32'sd7 << 16, 32'sd1 << 16, -32'sd9 << 16);
		load_body(BODY_SECOND, 32'sd2 << 16, -32'sd1 << 16, 32'sd3, 32'sd0);
		step_once();
		step_once();
	endtask

	// Random phases: each picks a configuration, sets up an orbit and mostly steps
	// it, with loose reloads and now and then full-range values.
	task automatic test_random_phases(int phases, int per_phase);
		int r;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 3))
				0: write_all_registers(24'd100000, 24'd30, 16'd1000, 16'd1092);
				1: write_all_registers(24'($urandom), 24'($urandom), 16'($urandom),
					16'($urandom_range(1, 65535)));
				2: write_all_registers(24'($urandom_range(1, 2000000)),
					24'($urandom_range(1, 5000)), 16'($urandom_range(0, 4000)),
					16'($urandom_range(200, 4000)));
				default: write_all_registers(24'($urandom_range(1, 300)),
					24'($urandom_range(1, 300)), 16'($urandom_range(0, 100)),
					16'($urandom_range(1, 65535)));
			endcase
			calm_receiver = (p % 4 == 3);
			load_body(BODY_FIRST, near_value(1 << 20), near_value(1 << 20),
				near_value(1 << 18), near_value(1 << 18));
			load_body(BODY_SECOND, near_value(1 << 24), near_value(1 << 24),
				near_value(1 << 22), near_value(1 << 22));
			for (int i = 0; i < per_phase; i++) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					step_once();
				else if (r < 94)
					load_body(1'($urandom), near_value(1 << 26), near_value(1 << 26),
						near_value(1 << 23), near_value(1 << 23));
				else
					load_body(1'($urandom), $urandom, $urandom, $urandom, $urandom);
			end
			// Pause once so the block runs completely dry between requests.
			if (p == 1)
				drain_results();
		end
		calm_receiver = 1'b0;
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_MASS_FIRST;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_STEP;
		body_sel = BODY_FIRST;
		load_pos_x = '0;
		load_pos_y = '0;
		load_vel_x = '0;
		load_vel_y = '0;
		error_count = 0;
		requests_sent = 0;
		results_seen = 0;
		loads_sent = 0;
		clipped_results = 0;
		cycle_count = 0;
		calm_receiver = 1'b0;
		mass_a = 64'd100000;
		mass_b = 64'd30;
		grav_k = 64'd1000;
		tick_len = 64'd1092;
		ax = 0; ay = 0; bx = 0; by = 0;
		avx = 0; avy = 0; bvx = 0; bvy = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_default_orbit();
		test_range_limits();
		test_config_extremes();
		test_random_phases(6, 96);

		drain_results();
		wait_cycles = 0;
		while (wait_cycles < SETTLE_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end

		$display("Covered %0d requests (%0d loads), %0d results checked, %0d clipped.",
			requests_sent, loads_sent, results_seen, clipped_results);
		$display("Configurations ranged from minimum to maximum mass, constant and tick.");
		if (error_count == 0 && expected_snapshots.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_mul.sv
hw/rtl/gbs_iter.sv
hw/rtl/two_body_gravity_step.sv
bench/tb_two_body_gravity_step.sv
